>>> rtl/mm_pkg.sv
// package for the modular multiply pipeline
// holds the default operand width and the number of bit steps per stage
// no dependencies
`timescale 1ns / 1ps

package mm_pkg;

    localparam int OPERAND_WIDTH_DEF = 63;
    // compare-subtract steps per reduction stage
    localparam int RED_STEPS_DEF     = 4;
    // double-add steps per multiply stage (two compare-subtracts each)
    localparam int MAC_STEPS_DEF     = 2;

endpackage

>>> rtl/mm_reduce_stage.sv
// one stage of the restoring reduction of the multiplicand by the modulus
// shifts STEPS multiplicand bits, msb first, into the partial remainder
// depends on mm_pkg for parameter defaults
`timescale 1ns / 1ps

module mm_reduce_stage #(
    parameter int OPERAND_WIDTH = mm_pkg::OPERAND_WIDTH_DEF,
    parameter int STEPS         = mm_pkg::RED_STEPS_DEF,
    parameter int BASE          = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OPERAND_WIDTH-1:0] i_x,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    input  logic [OPERAND_WIDTH-1:0] i_r,
    input  logic                     i_zero,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OPERAND_WIDTH-1:0] o_x,
    output logic [OPERAND_WIDTH-1:0] o_b,
    output logic [OPERAND_WIDTH-1:0] o_m,
    output logic [OPERAND_WIDTH-1:0] o_r,
    output logic                     o_zero
);

    logic                     r_valid;
    logic [OPERAND_WIDTH-1:0] r_x, r_b, r_m, r_r;
    logic                     r_zero;
    logic [OPERAND_WIDTH-1:0] n_r;

    always_comb begin
        logic [OPERAND_WIDTH:0] t;
        n_r = i_r;
        for (int j = 0; j < STEPS; j++) begin
            if (BASE + j < OPERAND_WIDTH) begin
                t = {n_r, i_x[OPERAND_WIDTH-1-BASE-j]};
                if (t >= {1'b0, i_m}) begin
                    t = t - {1'b0, i_m};
                end
                n_r = t[OPERAND_WIDTH-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_x    <= i_x;
            r_b    <= i_b;
            r_m    <= i_m;
            r_r    <= n_r;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_b     = r_b;
    assign o_m     = r_m;
    assign o_r     = r_r;
    assign o_zero  = r_zero;

endmodule

>>> rtl/mm_mac_stage.sv
// one stage of the interleaved modular multiply: r = 2r + bit*x mod m
// takes STEPS multiplier bits msb first; the first stage loads x from the reduction
// depends on mm_pkg for parameter defaults
`timescale 1ns / 1ps

module mm_mac_stage #(
    parameter int OPERAND_WIDTH = mm_pkg::OPERAND_WIDTH_DEF,
    parameter int STEPS         = mm_pkg::MAC_STEPS_DEF,
    parameter int BASE          = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OPERAND_WIDTH-1:0] i_x,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    input  logic [OPERAND_WIDTH-1:0] i_r,
    input  logic                     i_zero,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OPERAND_WIDTH-1:0] o_x,
    output logic [OPERAND_WIDTH-1:0] o_b,
    output logic [OPERAND_WIDTH-1:0] o_m,
    output logic [OPERAND_WIDTH-1:0] o_r,
    output logic                     o_zero
);

    logic                     r_valid;
    logic [OPERAND_WIDTH-1:0] r_x, r_b, r_m, r_r;
    logic                     r_zero;
    logic [OPERAND_WIDTH-1:0] n_x, n_r;

    always_comb begin
        logic [OPERAND_WIDTH:0] t;
        // first stage: the reduced multiplicand arrives in the remainder lane
        if (BASE == 0) begin
            n_x = i_r;
            n_r = '0;
        end else begin
            n_x = i_x;
            n_r = i_r;
        end
        for (int j = 0; j < STEPS; j++) begin
            if (BASE + j < OPERAND_WIDTH) begin
                t = {n_r, 1'b0};
                if (t >= {1'b0, i_m}) begin
                    t = t - {1'b0, i_m};
                end
                if (i_b[OPERAND_WIDTH-1-BASE-j]) begin
                    t = t + {1'b0, n_x};
                end
                if (t >= {1'b0, i_m}) begin
                    t = t - {1'b0, i_m};
                end
                n_r = t[OPERAND_WIDTH-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_x    <= n_x;
            r_b    <= i_b;
            r_m    <= i_m;
            r_r    <= n_r;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_b     = r_b;
    assign o_m     = r_m;
    assign o_r     = r_r;
    assign o_zero  = r_zero;

endmodule

>>> rtl/modular_multiply.sv
// Modular multiply: each beat carries multiplicand, multiplier and modulus and returns
// (multiplicand * multiplier) mod modulus, exact for every operand; a zero modulus gives 0.
// One beat is taken every cycle while the output is not stalled. Each beat passes through
// a chain of stage registers: first the multiplicand is reduced by the modulus,
// four bits a stage, then the multiplier is applied two bits a stage by double-and-add.
// Each stage takes a new beat whenever it is empty or its contents move on.
// depends on mm_pkg, mm_reduce_stage and mm_mac_stage
`timescale 1ns / 1ps

module modular_multiply #(
    parameter int OPERAND_WIDTH = mm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // multiplicand, multiplier, modulus, zero fill
    input  logic [((3*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // remainder, zero fill
    output logic [((OPERAND_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int W     = OPERAND_WIDTH;
    localparam int RS    = mm_pkg::RED_STEPS_DEF;
    localparam int MS    = mm_pkg::MAC_STEPS_DEF;
    localparam int NR    = (W + RS - 1) / RS;
    localparam int NM    = (W + MS - 1) / MS;
    localparam int N     = NR + NM;
    localparam int OUT_W = ((W + 7) / 8) * 8;

    logic         v_valid [0:N];
    logic         v_ready [0:N];
    logic [W-1:0] v_x     [0:N];
    logic [W-1:0] v_b     [0:N];
    logic [W-1:0] v_m     [0:N];
    logic [W-1:0] v_r     [0:N];
    logic         v_zero  [0:N];

    assign v_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = v_ready[0];
    assign v_x[0]        = s_axis_tdata[W-1:0];
    assign v_b[0]        = s_axis_tdata[2*W-1:W];
    assign v_m[0]        = s_axis_tdata[3*W-1:2*W];
    assign v_r[0]        = '0;
    assign v_zero[0]     = (s_axis_tdata[3*W-1:2*W] == '0);

    genvar k;
    generate
        for (k = 0; k < NR; k++) begin : g_red
            mm_reduce_stage #(
                .OPERAND_WIDTH(W),
                .STEPS        (RS),
                .BASE         (k * RS)
            ) u_stage (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_valid(v_valid[k]),
                .o_ready(v_ready[k]),
                .i_x    (v_x[k]),
                .i_b    (v_b[k]),
                .i_m    (v_m[k]),
                .i_r    (v_r[k]),
                .i_zero (v_zero[k]),
                .o_valid(v_valid[k+1]),
                .i_ready(v_ready[k+1]),
                .o_x    (v_x[k+1]),
                .o_b    (v_b[k+1]),
                .o_m    (v_m[k+1]),
                .o_r    (v_r[k+1]),
                .o_zero (v_zero[k+1])
            );
        end
        for (k = 0; k < NM; k++) begin : g_mac
            mm_mac_stage #(
                .OPERAND_WIDTH(W),
                .STEPS        (MS),
                .BASE         (k * MS)
            ) u_stage (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_valid(v_valid[NR+k]),
                .o_ready(v_ready[NR+k]),
                .i_x    (v_x[NR+k]),
                .i_b    (v_b[NR+k]),
                .i_m    (v_m[NR+k]),
                .i_r    (v_r[NR+k]),
                .i_zero (v_zero[NR+k]),
                .o_valid(v_valid[NR+k+1]),
                .i_ready(v_ready[NR+k+1]),
                .o_x    (v_x[NR+k+1]),
                .o_b    (v_b[NR+k+1]),
                .o_m    (v_m[NR+k+1]),
                .o_r    (v_r[NR+k+1]),
                .o_zero (v_zero[NR+k+1])
            );
        end
    endgenerate

    logic [W-1:0] w_rem;

    // zero modulus forces the result to zero
    assign w_rem         = v_zero[N] ? '0 : v_r[N];
    assign m_axis_tvalid = v_valid[N];
    assign v_ready[N]    = m_axis_tready;
    assign m_axis_tdata  = OUT_W'(w_rem);

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !v_zero[N] |-> v_r[N] < v_m[N])
        else $error("remainder not below modulus");

    a_zero_mod_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && v_zero[N] |-> m_axis_tdata == '0)
        else $error("zero modulus gave nonzero result");

    a_zero_flag_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> v_zero[N] == (v_m[N] == '0))
        else $error("zero flag lost track of modulus");

    a_out_drain_opens_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready && !v_valid[1] |-> s_axis_tready)
        else $error("input stalled with an empty first stage");

endmodule
